// ===== sv/ipsp_pkg.sv =====
// ============================================================================
// IPS patch parser package
// Shared types, result codes and format constants for the IPS patch parser.
// ============================================================================
`default_nettype none

package ipsp_pkg;

    // Field widths of the result beat.
    localparam int unsigned ADDR_W  = 25;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned RUN_W   = 16;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned OFFS_W  = 24;

    // Offset value that marks the end of the patch ("EOF").
    localparam logic [OFFS_W-1:0] EOF_OFFSET = 24'h454F46;

    // Result kinds, carried on the master-side tuser.
    typedef enum logic [2:0] {
        KIND_WRITE     = 3'd0,
        KIND_FILL      = 3'd1,
        KIND_EOF       = 3'd2,
        KIND_BAD_HDR   = 3'd3,
        KIND_NO_MARKER = 3'd4,
        KIND_TRUNCATED = 3'd5
    } t_kind;

    // One result item as it travels from the parser to the output buffer.
    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   address;
        logic [BYTE_W-1:0]   value;
        logic [RUN_W-1:0]    run_length;
        logic [ADDR_W-1:0]   image_size;
        logic [COUNT_W-1:0]  record_count;
    } t_result;

    // Expected header byte at each position of "PATCH".
    function automatic logic [BYTE_W-1:0] header_magic(input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = 8'h50;
            3'd1:    b = 8'h41;
            3'd2:    b = 8'h54;
            3'd3:    b = 8'h43;
            3'd4:    b = 8'h48;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ipsp_parser.sv =====
// ============================================================================
// IPS patch parser core
// Holds the parse state and turns each accepted byte or end beat into at most
// one result in the same cycle, updating the state registers at the edge.
// ============================================================================
`default_nettype none

module ipsp_parser (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_beat,
    input  wire logic                         i_func,
    input  wire logic [ipsp_pkg::BYTE_W-1:0]  i_byte,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [ipsp_pkg::ADDR_W-1:0]  i_cfg_wr_data,
    output logic                              o_res_valid,
    output ipsp_pkg::t_result                 o_res
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_OFFSET = 3'd1,
        PH_LENGTH = 3'd2,
        PH_DATA   = 3'd3,
        PH_RUNLEN = 3'd4,
        PH_FILL   = 3'd5
    } t_phase;

    t_phase                          r_phase,    n_phase;
    logic [2:0]                      r_idx,      n_idx;
    logic [ipsp_pkg::OFFS_W-1:0]     r_offset,   n_offset;
    logic [ipsp_pkg::RUN_W-1:0]      r_rec_len,  n_rec_len;
    logic [ipsp_pkg::RUN_W-1:0]      r_remain,   n_remain;
    logic [ipsp_pkg::ADDR_W-1:0]     r_wr_addr,  n_wr_addr;
    logic [ipsp_pkg::ADDR_W-1:0]     r_img_size, n_img_size;
    logic [ipsp_pkg::COUNT_W-1:0]    r_rec_cnt,  n_rec_cnt;
    logic                            r_finished, n_finished;

    logic [ipsp_pkg::RUN_W-1:0]      w_len_new;
    logic [ipsp_pkg::ADDR_W-1:0]     w_end;
    logic                            w_grow;
    logic [ipsp_pkg::COUNT_W-1:0]    w_cnt_inc;

    // Length being assembled and the image end it would reach.
    assign w_len_new = {r_rec_len[ipsp_pkg::BYTE_W-1:0], i_byte};
    assign w_end     = {1'b0, r_offset} + {{(ipsp_pkg::ADDR_W-ipsp_pkg::RUN_W){1'b0}}, w_len_new};
    assign w_grow    = (w_end > r_img_size);
    assign w_cnt_inc = (r_rec_cnt == {ipsp_pkg::COUNT_W{1'b1}}) ? r_rec_cnt
                                                                 : r_rec_cnt + 1'b1;

    // Next state and result for the beat at hand.
    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_offset   = r_offset;
        n_rec_len  = r_rec_len;
        n_remain   = r_remain;
        n_wr_addr  = r_wr_addr;
        n_img_size = r_img_size;
        n_rec_cnt  = r_rec_cnt;
        n_finished = r_finished;

        o_res_valid      = 1'b0;
        o_res.kind       = ipsp_pkg::KIND_WRITE;
        o_res.address    = '0;
        o_res.value      = '0;
        o_res.run_length = '0;

        // The size register also presets the image size while the parser is still in the header phase.
        if (i_cfg_wr_en && r_phase == PH_HEADER && !r_finished) begin
            n_img_size = i_cfg_wr_data;
        end

        if (i_beat && !r_finished) begin
            if (i_func) begin
                n_finished  = 1'b1;
                o_res_valid = 1'b1;
                if (r_phase == PH_HEADER) begin
                    o_res.kind = ipsp_pkg::KIND_BAD_HDR;
                end else if (r_phase == PH_OFFSET && r_idx == 3'd0) begin
                    o_res.kind = ipsp_pkg::KIND_NO_MARKER;
                end else begin
                    o_res.kind = ipsp_pkg::KIND_TRUNCATED;
                end
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (i_byte != ipsp_pkg::header_magic(r_idx)) begin
                            n_finished  = 1'b1;
                            o_res_valid = 1'b1;
                            o_res.kind  = ipsp_pkg::KIND_BAD_HDR;
                        end else if (r_idx == 3'd4) begin
                            n_phase  = PH_OFFSET;
                            n_idx    = 3'd0;
                            n_offset = '0;
                        end else begin
                            n_idx = r_idx + 3'd1;
                        end
                    end
                    PH_OFFSET: begin
                        n_offset = {r_offset[ipsp_pkg::OFFS_W-ipsp_pkg::BYTE_W-1:0], i_byte};
                        if (r_idx == 3'd2) begin
                            n_idx = 3'd0;
                            if (n_offset == ipsp_pkg::EOF_OFFSET) begin
                                n_finished  = 1'b1;
                                o_res_valid = 1'b1;
                                o_res.kind  = ipsp_pkg::KIND_EOF;
                            end else begin
                                n_phase   = PH_LENGTH;
                                n_rec_len = '0;
                            end
                        end else begin
                            n_idx = r_idx + 3'd1;
                        end
                    end
                    PH_LENGTH: begin
                        n_rec_len = w_len_new;
                        if (r_idx == 3'd1) begin
                            n_idx = 3'd0;
                            if (w_len_new != '0) begin
                                if (w_grow) begin
                                    n_img_size = w_end;
                                end
                                n_remain  = w_len_new;
                                n_wr_addr = {1'b0, r_offset};
                                n_phase   = PH_DATA;
                            end else begin
                                n_phase = PH_RUNLEN;
                            end
                        end else begin
                            n_idx = r_idx + 3'd1;
                        end
                    end
                    PH_DATA: begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = ipsp_pkg::KIND_WRITE;
                        o_res.address    = r_wr_addr;
                        o_res.value      = i_byte;
                        o_res.run_length = {{(ipsp_pkg::RUN_W-1){1'b0}}, 1'b1};
                        n_wr_addr        = r_wr_addr + 1'b1;
                        n_remain         = r_remain - 1'b1;
                        // Last data byte closes the record.
                        if (r_remain <= {{(ipsp_pkg::RUN_W-1){1'b0}}, 1'b1}) begin
                            n_remain  = '0;
                            n_rec_cnt = w_cnt_inc;
                            n_phase   = PH_OFFSET;
                            n_idx     = 3'd0;
                            n_offset  = '0;
                        end
                    end
                    PH_RUNLEN: begin
                        n_rec_len = w_len_new;
                        if (r_idx == 3'd1) begin
                            n_idx = 3'd0;
                            if (w_len_new != '0 && w_grow) begin
                                n_img_size = w_end;
                            end
                            n_phase = PH_FILL;
                        end else begin
                            n_idx = r_idx + 3'd1;
                        end
                    end
                    PH_FILL: begin
                        n_rec_cnt = w_cnt_inc;
                        n_phase   = PH_OFFSET;
                        n_idx     = 3'd0;
                        n_offset  = '0;
                        // A zero run length is counted but writes nothing.
                        if (r_rec_len != '0) begin
                            o_res_valid      = 1'b1;
                            o_res.kind       = ipsp_pkg::KIND_FILL;
                            o_res.address    = {1'b0, r_offset};
                            o_res.value      = i_byte;
                            o_res.run_length = r_rec_len;
                        end
                    end
                    default: begin
                        n_finished = 1'b1;
                    end
                endcase
            end
        end

        o_res.image_size   = n_img_size;
        o_res.record_count = n_rec_cnt;
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_idx      <= 3'd0;
            r_offset   <= '0;
            r_rec_len  <= '0;
            r_remain   <= '0;
            r_wr_addr  <= '0;
            r_img_size <= '0;
            r_rec_cnt  <= '0;
            r_finished <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_offset   <= n_offset;
            r_rec_len  <= n_rec_len;
            r_remain   <= n_remain;
            r_wr_addr  <= n_wr_addr;
            r_img_size <= n_img_size;
            r_rec_cnt  <= n_rec_cnt;
            r_finished <= n_finished;
        end
    end

`ifndef SYNTHESIS
    // Once finished, the parser stays finished until reset.
    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("parser left the finished state without reset");

    // A finished parser produces no further results.
    a_no_result_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> !o_res_valid)
        else $error("result produced after the parser finished");

    // The image size only grows unless the size register is written.
    a_image_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cfg_wr_en && !n_finished && r_phase != PH_HEADER) |=> r_img_size >= $past(r_img_size))
        else $error("image size shrank during parsing");
`endif

endmodule

`default_nettype wire

// ===== sv/ipsp_out_buf.sv =====
// ============================================================================
// IPS patch parser output buffer
// Two-entry result register that keeps the byte side flowing while the
// result side stalls.
// ============================================================================
`default_nettype none

module ipsp_out_buf (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire ipsp_pkg::t_result    i_res,
    output logic                      o_space,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output ipsp_pkg::t_result         o_res
);

    ipsp_pkg::t_result  r_mem [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic               w_pop;

    assign o_space = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_res   = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    // A push never lands on a full buffer.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2 || w_pop))
        else $error("result pushed into a full buffer");

    // Fill level agrees with the pointer distance.
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))
        else $error("buffer fill level disagrees with pointers");
`endif

endmodule

`default_nettype wire

// ===== sv/ips_patch_stream_parser_unit.sv =====
// ============================================================================
// IPS patch stream parser
// Parses an IPS patch byte stream into image write and fill commands.
// ============================================================================
// The block takes one patch byte (tuser = 0) or one end-of-stream beat
// (tuser = 1) in every clock cycle while tready is high and delivers its
// result, if any, on the master side through a two-entry output buffer.
// Each beat is handled by one update of the parser state, so the sustained
// rate is one beat per cycle while results drain. The buffer lets the slave
// side keep accepting beats while the master side is stalled; tready falls
// only when both entries hold undelivered results. Writing the size register
// before the first header byte presets the starting image size.
`default_nettype none

module ips_patch_stream_parser_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Size register write port.
    input  wire logic          i_cfg_wr_en,
    input  wire logic [24:0]   i_cfg_wr_data,
    // Patch byte stream.
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] patch_byte
    input  wire logic          s_axis_tuser,   // [0] func
    // Result stream.
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [95:0]        m_axis_tdata,   // [24:0] address, [32:25] value,
                                               // [48:33] run_length,
                                               // [73:49] image_size,
                                               // [89:74] record_count,
                                               // [95:90] zero
    output logic [2:0]         m_axis_tuser    // [2:0] kind
);

    logic               w_accept;
    logic               w_res_valid;
    ipsp_pkg::t_result  w_res;
    ipsp_pkg::t_result  w_out;
    logic               w_space;

    assign s_axis_tready = w_space;
    assign w_accept      = s_axis_tvalid && w_space;

    // Parser state and result decode.
    ipsp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat        (w_accept),
        .i_func        (s_axis_tuser),
        .i_byte        (s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    // Result register with room for one stalled beat.
    ipsp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_space (w_space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (w_out)
    );

    // Pack the result beat, first field in the lowest bits.
    assign m_axis_tuser = w_out.kind;
    assign m_axis_tdata = {6'b0, w_out.record_count, w_out.image_size,
                           w_out.run_length, w_out.value, w_out.address};

endmodule

`default_nettype wire
